/* rtl/rlh_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlh_pkg
// Shared constants, payload types and control structs of the run-length
// level histogram.
// ----------------------------------------------------------------------------
package rlh_pkg;

   localparam int MAX_WIDTH     = 32;
   localparam int HIST_BINS     = 64;
   localparam int POSITION_BITS = 20;

   localparam int LVL_W      = $clog2(MAX_WIDTH);
   localparam int BIN_W      = $clog2(HIST_BINS);
   localparam int HIST_DEPTH = MAX_WIDTH * HIST_BINS;
   localparam int HADDR_W    = $clog2(HIST_DEPTH);
   localparam int POS_W      = POSITION_BITS;
   localparam int LEN_W      = 20;
   localparam int CNT_W      = 32;

   localparam logic [LEN_W-1:0] LEN_SAT = '1;

   localparam logic [1:0] OP_SAMPLE = 2'd0;
   localparam logic [1:0] OP_READ   = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic KIND_RUN = 1'b0;
   localparam logic KIND_BIN = 1'b1;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  width_sample;
      logic        first_sample;
      logic        last_sample;
      logic [19:0] start_position;
      logic [4:0]  read_level;
      logic [5:0]  read_bin;
   } rlh_req_type;

   typedef struct packed {
      logic        result_kind;
      logic [4:0]  run_level;
      logic [19:0] run_start;
      logic [19:0] run_length;
      logic [31:0] bin_value;
      logic        last_of_run;
   } rlh_rsp_type;

   typedef struct packed {
      logic               step;
      logic               bin_rd;
      logic               close_rd;
      logic               close_wr;
      logic               close_last;
      logic               bin_load;
      logic               tail;
      logic               clr_wr;
      logic [LVL_W-1:0]   level;
      logic [HADDR_W-1:0] clr_addr;
   } rlh_cmd_type;

   typedef struct packed {
      logic             close_any;
      logic [LVL_W-1:0] close_top;
      logic [LVL_W-1:0] close_bot;
      logic             out_free;
   } rlh_sts_type;

endpackage

/* rtl/rlh_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlh channel interfaces
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface rlh_req_if;
   import rlh_pkg::*;
   logic        valid;
   logic        ready;
   rlh_req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface rlh_rsp_if;
   import rlh_pkg::*;
   logic        valid;
   logic        ready;
   rlh_rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* rtl/rlh_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlh_datapath
// Per-level run registers, histogram memory with saturating update, and the
// result output register.
// ----------------------------------------------------------------------------
module rlh_datapath (
   input  logic                clock,
   input  logic                reset,
   input  rlh_pkg::rlh_cmd_type cmd,
   input  rlh_pkg::rlh_req_type req_pl,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output rlh_pkg::rlh_rsp_type rsp_pl,
   output rlh_pkg::rlh_sts_type sts
);
   import rlh_pkg::*;

   logic [LEN_W-1:0]   len_ff   [MAX_WIDTH];
   logic [POS_W-1:0]   start_ff [MAX_WIDTH];
   logic [LVL_W-1:0]   prev_ff;
   logic [POS_W-1:0]   pos_ff;
   logic [LVL_W-1:0]   cur_ff;
   logic               first_ff;
   logic               last_ff;

   logic [CNT_W-1:0]   mem [HIST_DEPTH];
   logic [CNT_W-1:0]   rdata_ff;

   logic [HADDR_W-1:0] addr_ff;
   logic [LEN_W-1:0]   amt_ff;
   logic [LVL_W-1:0]   cl_level_ff;
   logic [POS_W-1:0]   cl_start_ff;
   logic [LEN_W-1:0]   cl_len_ff;
   logic               in_range_ff;

   logic               rsp_valid_ff;
   rlh_rsp_type        rsp_ff;

   logic [LVL_W-1:0]   cur_in;
   logic               drop_in;
   logic [POS_W-1:0]   pos_next;
   logic [POS_W-1:0]   sp_in;
   logic [LEN_W-1:0]   sel_len;
   logic               over;
   logic [BIN_W-1:0]   sel_bin;
   logic [LEN_W-1:0]   sel_amt;
   logic [HADDR_W-1:0] close_addr;
   logic [HADDR_W-1:0] bin_addr;
   logic [HADDR_W-1:0] rd_addr;
   logic               bin_in_range;
   logic [CNT_W:0]     sum;
   logic [CNT_W-1:0]   sat_val;
   logic               mem_we;
   logic [HADDR_W-1:0] wr_addr;
   logic [CNT_W-1:0]   wr_data;

   assign cur_in = (req_pl.width_sample > 8'(MAX_WIDTH - 1)) ? LVL_W'(MAX_WIDTH - 1)
                                                             : LVL_W'(req_pl.width_sample);
   assign drop_in  = !req_pl.first_sample && (prev_ff > cur_in);
   assign pos_next = pos_ff + 1'b1;
   assign sp_in    = POS_W'(req_pl.start_position);

   // closing range: a drop closes prev..cur+1, a last sample continues down to 1
   assign sts.close_any = drop_in || (req_pl.last_sample && (cur_in != '0));
   assign sts.close_top = drop_in ? prev_ff : cur_in;
   assign sts.close_bot = req_pl.last_sample ? LVL_W'(1) : LVL_W'(cur_in + 1'b1);
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   assign sel_len    = len_ff[cmd.level];
   assign over       = sel_len > LEN_W'(HIST_BINS - 1);
   assign sel_bin    = over ? BIN_W'(HIST_BINS - 1) : BIN_W'(sel_len);
   assign sel_amt    = over ? LEN_W'(sel_len / HIST_BINS - 1) : LEN_W'(1);
   assign close_addr = HADDR_W'(cmd.level * HIST_BINS) + HADDR_W'(sel_bin);
   assign bin_addr   = HADDR_W'(req_pl.read_level * HIST_BINS + req_pl.read_bin);
   assign rd_addr    = cmd.bin_rd ? bin_addr : close_addr;
   assign bin_in_range = (int'(req_pl.read_level) < MAX_WIDTH)
                      && (int'(req_pl.read_bin) < HIST_BINS);

   assign sum     = (CNT_W+1)'(rdata_ff) + (CNT_W+1)'(amt_ff);
   assign sat_val = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
   assign mem_we  = cmd.clr_wr || cmd.close_wr;
   assign wr_addr = cmd.clr_wr ? cmd.clr_addr : addr_ff;
   assign wr_data = cmd.clr_wr ? '0 : sat_val;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.bin_rd || cmd.close_rd) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.close_rd) begin
         addr_ff     <= close_addr;
         amt_ff      <= sel_amt;
         cl_level_ff <= cmd.level;
         cl_start_ff <= start_ff[cmd.level];
         cl_len_ff   <= sel_len;
      end
      if (cmd.bin_rd) begin
         in_range_ff <= bin_in_range;
      end
      if (cmd.step) begin
         cur_ff   <= cur_in;
         first_ff <= req_pl.first_sample;
         last_ff  <= req_pl.last_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_WIDTH; i++) begin
            len_ff[i]   <= '0;
            start_ff[i] <= '0;
         end
         prev_ff <= '0;
         pos_ff  <= '0;
      end else if (cmd.step) begin
         for (int i = 0; i < MAX_WIDTH; i++) begin
            if (req_pl.first_sample) begin
               len_ff[i]   <= (LVL_W'(i) <= cur_in) ? LEN_W'(1) : '0;
               start_ff[i] <= sp_in;
            end else begin
               if (LVL_W'(i) <= cur_in && len_ff[i] != LEN_SAT) begin
                  len_ff[i] <= len_ff[i] + 1'b1;
               end
               if (LVL_W'(i) > prev_ff && LVL_W'(i) <= cur_in) begin
                  start_ff[i] <= pos_next;
               end
            end
         end
         pos_ff  <= req_pl.first_sample ? sp_in : pos_next;
         prev_ff <= cur_in;
      end else if (cmd.tail) begin
         // pos_ff already holds this sample's position
         for (int i = 0; i < MAX_WIDTH; i++) begin
            if (!first_ff && LVL_W'(i) > cur_ff) begin
               start_ff[i] <= pos_next;
            end
            if (last_ff || (!first_ff && LVL_W'(i) > cur_ff)) begin
               len_ff[i] <= '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.close_wr || cmd.bin_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.close_wr) begin
         rsp_ff.result_kind <= KIND_RUN;
         rsp_ff.run_level   <= 5'(cl_level_ff);
         rsp_ff.run_start   <= 20'(cl_start_ff);
         rsp_ff.run_length  <= cl_len_ff;
         rsp_ff.bin_value   <= '0;
         rsp_ff.last_of_run <= cmd.close_last;
      end else if (cmd.bin_load) begin
         rsp_ff.result_kind <= KIND_BIN;
         rsp_ff.run_level   <= '0;
         rsp_ff.run_start   <= '0;
         rsp_ff.run_length  <= '0;
         rsp_ff.bin_value   <= in_range_ff ? rdata_ff : '0;
         rsp_ff.last_of_run <= 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pl    = rsp_ff;

endmodule

/* rtl/rlh_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlh_ctrl
// Sequencer: histogram clearing sweep, item decode, per-level close loop.
// ----------------------------------------------------------------------------
module rlh_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [1:0]          req_opcode,
   output logic                req_ready,
   input  rlh_pkg::rlh_sts_type sts,
   output rlh_pkg::rlh_cmd_type cmd
);
   import rlh_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_CL_RD, ST_CL_WR, ST_BIN, ST_TAIL
   } state_type;

   state_type          state_ff, state_in;
   logic [LVL_W-1:0]   level_ff, level_in;
   logic [LVL_W-1:0]   bot_ff, bot_in;
   logic [HADDR_W-1:0] clr_ff, clr_in;
   logic               accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      level_in = level_ff;
      bot_in   = bot_ff;
      clr_in   = clr_ff;
      cmd      = '0;
      cmd.level      = level_ff;
      cmd.clr_addr   = clr_ff;
      cmd.close_last = (level_ff == bot_ff);
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == HADDR_W'(HIST_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_opcode)
                  OP_SAMPLE: begin
                     cmd.step = 1'b1;
                     level_in = sts.close_top;
                     bot_in   = sts.close_bot;
                     state_in = sts.close_any ? ST_CL_RD : ST_TAIL;
                  end
                  OP_READ: begin
                     cmd.bin_rd = 1'b1;
                     state_in   = ST_BIN;
                  end
                  OP_CLEAR: begin
                     clr_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_CL_RD: begin
            cmd.close_rd = 1'b1;
            state_in     = ST_CL_WR;
         end
         ST_CL_WR: begin
            if (sts.out_free) begin
               cmd.close_wr = 1'b1;
               if (level_ff == bot_ff) begin
                  state_in = ST_TAIL;
               end else begin
                  level_in = level_ff - 1'b1;
                  state_in = ST_CL_RD;
               end
            end
         end
         ST_BIN: begin
            if (sts.out_free) begin
               cmd.bin_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_TAIL: begin
            cmd.tail = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         level_ff <= '0;
         bot_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         level_ff <= level_in;
         bot_ff   <= bot_in;
      end
   end

endmodule

/* rtl/run_length_level_histogram_core.sv */
// Sequence: a sample steps in IDLE, then CL_RD and CL_WR per closed run,
// then TAIL; a bin read passes BIN; a clear zeroes all 2048 words.
// One item at a time; the histogram memory's single write port and the
// read-modify-write per closed run set the rate.
// Reset: synchronous; run state clears at once, then a clearing pass of
// the histogram runs with req ready low.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// run_length_level_histogram_core
// Run-length level histogram: emits closed runs per width level and counts
// them in a level-by-length histogram.
// ----------------------------------------------------------------------------
module run_length_level_histogram_core (
   input  logic       clock,
   input  logic       reset,
   rlh_req_if.sink    req_chan,
   rlh_rsp_if.source  rsp_chan
);
   import rlh_pkg::*;

   rlh_cmd_type cmd;
   rlh_sts_type sts;

   rlh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_opcode (req_chan.payload.opcode),
      .req_ready  (req_chan.ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   rlh_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_pl    (req_chan.payload),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_pl    (rsp_chan.payload),
      .sts       (sts)
   );

endmodule

/* rtl/rlh_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlh_checker
// Port-level checks of the run-length level histogram, bound to the top.
// ----------------------------------------------------------------------------
module rlh_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input rlh_pkg::rlh_rsp_type rsp_pl
);
   import rlh_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pl))
      else $error("result item dropped or changed while stalled");

   a_bin_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pl.result_kind == KIND_BIN |->
         rsp_pl.run_level == '0 && rsp_pl.run_length == '0 && rsp_pl.last_of_run)
      else $error("bin read item carries run fields");

   a_run_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pl.result_kind == KIND_RUN |->
         rsp_pl.bin_value == '0 && rsp_pl.run_level != '0)
      else $error("closed run item malformed");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("ready during histogram clearing pass");

endmodule

bind run_length_level_histogram_core rlh_checker u_rlh_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_pl    (rsp_chan.payload)
);

/* test/tb_run_length_level_histogram_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_run_length_level_histogram_core
// Drives width samples, bin reads and clears into the run-length level
// histogram core with bursty input and a stalling receiver, predicts every
// closed run and bin value, and compares the results in order.
// ----------------------------------------------------------------------------
module tb_run_length_level_histogram_core;
   import rlh_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rlh_req_if req_chan ();
   rlh_rsp_if rsp_chan ();

   run_length_level_histogram_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always #6 clock = ~clock;

   // predictor state
   logic [LEN_W-1:0] lvl_len   [MAX_WIDTH];
   logic [POS_W-1:0] lvl_start [MAX_WIDTH];
   logic [LVL_W-1:0] prev_width;
   logic [POS_W-1:0] cur_pos;
   logic [CNT_W-1:0] hist      [HIST_DEPTH];

   rlh_req_type pending_items [$];
   rlh_rsp_type expected_results [$];
   int          mismatch_count = 0;
   bit          hold_off = 1'b0;
   int          idle_cycles = 0;

   function automatic void enqueue_item(rlh_req_type it);
      pending_items = {pending_items, it};
   endfunction

   function automatic void hist_bump(int lv, int bn, logic [CNT_W-1:0] amount);
      int idx;
      idx = lv * HIST_BINS + bn;
      if ({1'b0, hist[idx]} + {1'b0, amount} > 33'hFFFF_FFFF)
         hist[idx] = '1;
      else
         hist[idx] = hist[idx] + amount;
   endfunction

   function automatic void close_run(int lv);
      rlh_rsp_type r;
      r = '0;
      r.result_kind = KIND_RUN;
      r.run_level   = 5'(lv);
      r.run_start   = lvl_start[lv];
      r.run_length  = lvl_len[lv];
      if (lvl_len[lv] > HIST_BINS - 1)
         hist_bump(lv, HIST_BINS - 1, CNT_W'((lvl_len[lv] / HIST_BINS) - 1));
      else
         hist_bump(lv, int'(lvl_len[lv]), 1);
      expected_results = {expected_results, r};
   endfunction

   function automatic void predict_item(rlh_req_type it);
      int cur, last, n0, i;
      logic [POS_W-1:0] x;
      rlh_rsp_type r;
      n0 = expected_results.size();
      if (it.opcode == OP_READ) begin
         r = '0;
         r.result_kind = KIND_BIN;
         r.bin_value   = hist[it.read_level * HIST_BINS + it.read_bin];
         r.last_of_run = 1'b1;
         expected_results = {expected_results, r};
         return;
      end
      if (it.opcode == OP_CLEAR) begin
         for (i = 0; i < HIST_DEPTH; i++) hist[i] = '0;
         return;
      end
      if (it.opcode != OP_SAMPLE) return;
      cur = (it.width_sample > MAX_WIDTH - 1) ? MAX_WIDTH - 1 : int'(it.width_sample);
      if (it.first_sample) begin
         for (i = 0; i < MAX_WIDTH; i++) begin
            lvl_len[i]   = '0;
            lvl_start[i] = it.start_position;
         end
         cur_pos = it.start_position;
         for (i = 0; i <= cur; i++) if (lvl_len[i] != LEN_SAT) lvl_len[i]++;
      end else begin
         x = cur_pos + 1'b1;
         last = int'(prev_width);
         cur_pos = x;
         for (i = last + 1; i <= cur; i++) lvl_start[i] = x;
         for (i = 0; i <= cur; i++) if (lvl_len[i] != LEN_SAT) lvl_len[i]++;
         for (i = last; i > cur; i--) close_run(i);
         for (i = cur + 1; i < MAX_WIDTH; i++) begin
            lvl_start[i] = x + 1'b1;
            lvl_len[i]   = '0;
         end
      end
      prev_width = LVL_W'(cur);
      if (it.last_sample) begin
         for (i = cur; i > 0; i--) close_run(i);
         for (i = 0; i < MAX_WIDTH; i++) lvl_len[i] = '0;
      end
      if (expected_results.size() > n0)
         expected_results[expected_results.size()-1].last_of_run = 1'b1;
   endfunction

   // driver: bursts and gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid   <= 1'b0;
         req_chan.payload <= '0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (req_chan.valid) predict_item(req_chan.payload);
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_chan.valid <= 1'b0;
         end else if (pending_items.size() > 0 && !hold_off) begin
            req_chan.valid   <= 1'b1;
            req_chan.payload <= pending_items.pop_front();
            if (burst_left > 0) begin
               burst_left <= burst_left - 1;
            end else begin
               burst_left <= $urandom_range(0, 12);
               gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
            end
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // receiver stall pattern: phases of always-ready and random stalls
   int stall_phase = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         stall_phase <= (stall_phase + 1) % 160;
         if (stall_phase < 50)
            rsp_chan.ready <= 1'b1;
         else if (stall_phase < 110)
            rsp_chan.ready <= ($urandom_range(0, 3) != 0);
         else
            rsp_chan.ready <= ($urandom_range(0, 1) == 0);
      end
   end

   // monitor and watchdog
   always @(posedge clock) begin
      rlh_rsp_type want, got;
      if (!reset) begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = rsp_chan.payload;
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result %h", got);
            end else begin
               want = expected_results.pop_front();
               if (want.result_kind !== got.result_kind || want.run_level !== got.run_level
                   || want.run_start !== got.run_start || want.run_length !== got.run_length
                   || want.bin_value !== got.bin_value
                   || want.last_of_run !== got.last_of_run) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: expected %h actual %h", want, got);
               end
            end
         end
      end
   end

   function automatic rlh_req_type sample_item(int w, bit first, bit last);
      rlh_req_type it;
      it = '0;
      it.opcode = OP_SAMPLE;
      it.width_sample = 8'(w);
      it.first_sample = first;
      it.last_sample = last;
      it.start_position = 20'($urandom);
      it.read_level = 5'($urandom);
      it.read_bin = 6'($urandom);
      return it;
   endfunction

   function automatic rlh_req_type read_item(int lv, int bn);
      rlh_req_type it;
      it = '0;
      it.opcode = OP_READ;
      it.width_sample = 8'($urandom);
      it.first_sample = 1'($urandom);
      it.last_sample = 1'($urandom);
      it.start_position = 20'($urandom);
      it.read_level = 5'(lv);
      it.read_bin = 6'(bn);
      return it;
   endfunction

   initial begin
      rlh_req_type it;
      int i, w, n, k;
      for (i = 0; i < MAX_WIDTH; i++) begin
         lvl_len[i] = '0;
         lvl_start[i] = '0;
      end
      for (i = 0; i < HIST_DEPTH; i++) hist[i] = '0;
      prev_width = '0;
      cur_pos = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: continuation from reset, extremes, clipping, wrap, ops
      enqueue_item(sample_item(3, 0, 0));
      enqueue_item(sample_item(1, 0, 0));
      it = sample_item(255, 1, 0);
      it.start_position = 20'hFFFFE;
      enqueue_item(it);
      enqueue_item(sample_item(31, 0, 0));
      enqueue_item(sample_item(31, 0, 0));
      enqueue_item(sample_item(0, 0, 0));
      enqueue_item(sample_item(5, 0, 1));
      enqueue_item(sample_item(4, 0, 0));
      enqueue_item(sample_item(7, 0, 1));
      enqueue_item(sample_item(0, 1, 1));
      enqueue_item(sample_item(31, 1, 1));
      enqueue_item(read_item(31, 1));
      enqueue_item(read_item(0, 0));
      enqueue_item(read_item(31, 63));
      enqueue_item(read_item(3, 1));
      it = sample_item(0, 0, 0);
      it.opcode = OP_UNUSED;
      enqueue_item(it);
      it = sample_item(0, 0, 0);
      it.opcode = OP_CLEAR;
      enqueue_item(it);
      enqueue_item(read_item(31, 1));
      // long run (> HIST_BINS) to hit the overflow bin
      enqueue_item(sample_item(2, 1, 0));
      for (i = 0; i < 140; i++) enqueue_item(sample_item(2, 0, 0));
      enqueue_item(sample_item(0, 0, 0));
      enqueue_item(read_item(2, 63));
      enqueue_item(read_item(1, 63));

      wait (pending_items.size() == 0 && !req_chan.valid);
      hold_off = 1'b1;
      wait (expected_results.size() == 0);
      repeat (10) @(posedge clock);
      hold_off = 1'b0;

      // random curves with slowly changing width, plus noise
      n = 0;
      while (n < 90) begin
         k = $urandom_range(0, 9);
         if (k < 7) begin
            w = $urandom_range(0, 31);
            enqueue_item(sample_item(w, 1, 0));
            repeat ($urandom_range(2, 12)) begin
               w = w + $urandom_range(0, 6) - 3;
               if (w < 0) w = 0;
               enqueue_item(sample_item(($urandom_range(0, 15) == 0)
                  ? $urandom_range(0, 255) : w, 0, 0));
               n++;
            end
            enqueue_item(sample_item($urandom_range(0, 31), 0, 1));
            n += 2;
         end else if (k < 9) begin
            enqueue_item(read_item($urandom_range(0, 31), $urandom_range(0, 63)));
            n++;
         end else begin
            it = sample_item($urandom_range(0, 255), 1'($urandom), 1'($urandom));
            it.opcode = ($urandom_range(0, 3) == 0) ? OP_CLEAR : 2'($urandom_range(0, 3));
            enqueue_item(it);
            n++;
         end
      end
      for (i = 0; i < 8; i++)
         enqueue_item(read_item($urandom_range(0, 31), $urandom_range(0, 3)));

      wait (pending_items.size() == 0 && !req_chan.valid);
      wait (expected_results.size() == 0);
      repeat (3000) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
